@@ hdl/ond_pkg.sv @@
// Shared widths for the octahedral normal decoder.
package ond_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

endpackage

@@ hdl/octahedral_normal_decode_top.sv @@
// Root width LW = max(FRAC_BITS, 15) + 1 and quotient width QW = FRAC_BITS + 2.
// Throughput: one request per cycle unless the output stalls; the whole pipeline advances
// together, one sqrt stage per root bit and one divider stage per quotient bit.
// When the output register holds a request that is not taken, the pipeline holds.
// Reset is synchronous and active low; it clears every valid bit, payload stays as is.
// Top level of the octahedral normal decoder.
module octahedral_normal_decode_top import ond_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [IN_W-1:0]  i_enc_x,
    input  logic [IN_W-1:0]  i_enc_y,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_norm_x,
    output logic [OUT_W-1:0] o_norm_y,
    output logic [OUT_W-1:0] o_norm_z,
    output logic             o_fell_back
);

    localparam int MAXM = (FRAC_BITS > 15) ? FRAC_BITS : 15;
    localparam int MW   = MAXM + 1;
    localparam int CW   = MW + 1;
    localparam int LW   = MW;
    localparam int SW   = 2 * LW;

    logic en;

    logic                 pr_valid;
    logic signed [CW-1:0] pr_x, pr_y, pr_z;
    logic [SW-1:0]        pr_sum;

    logic                 sq_valid;
    logic [LW-1:0]        sq_len;
    logic [3*CW-1:0]      sq_side;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    ond_prep #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW),
        .SW        (SW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_x     (i_enc_x),
        .i_y     (i_enc_y),
        .o_valid (pr_valid),
        .o_x     (pr_x),
        .o_y     (pr_y),
        .o_z     (pr_z),
        .o_sum   (pr_sum)
    );

    ond_sqrt #(
        .LW (LW),
        .PW (3 * CW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pr_valid),
        .i_s     (pr_sum),
        .i_side  ({pr_x, pr_y, pr_z}),
        .o_valid (sq_valid),
        .o_len   (sq_len),
        .o_side  (sq_side)
    );

    ond_div #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW),
        .LW        (LW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_len   (sq_len),
        .i_x     (sq_side[3*CW-1:2*CW]),
        .i_y     (sq_side[2*CW-1:CW]),
        .i_z     (sq_side[CW-1:0]),
        .o_valid (o_valid),
        .o_x     (o_norm_x),
        .o_y     (o_norm_y),
        .o_z     (o_norm_z),
        .o_flag  (o_fell_back)
    );

endmodule

@@ hdl/ond_prep.sv @@
// Front end: clamp the code, form z, fold the lower hemisphere, and sum the squares.
module ond_prep import ond_pkg::*; #(
    parameter int FRAC_BITS = 14,
    parameter int CW        = 18,
    parameter int SW        = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [IN_W-1:0]      i_x,
    input  logic [IN_W-1:0]      i_y,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [CW-1:0] o_z,
    output logic [SW-1:0]        o_sum
);

    localparam logic signed [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [3:0] r_vld;

    logic signed [CW-1:0] r1_x, r1_y;
    logic signed [CW-1:0] r2_x, r2_y, r2_z;
    logic signed [CW-1:0] r3_x, r3_y, r3_z;
    logic [SW-1:0]        r3_sqx, r3_sqy, r3_sqz;
    logic signed [CW-1:0] r4_x, r4_y, r4_z;
    logic [SW-1:0]        r4_sum;

    logic signed [CW-1:0] n1_x, n1_y, ex_x, ex_y;
    logic signed [CW-1:0] ax, ay, n2_z, n2_x, n2_y;
    logic signed [2*CW-1:0] p_x, p_y, p_z;

    always_comb begin
        ex_x = {{(CW-IN_W){i_x[IN_W-1]}}, i_x};
        ex_y = {{(CW-IN_W){i_y[IN_W-1]}}, i_y};
        n1_x = (ex_x > ONE) ? ONE : ((ex_x < -ONE) ? -ONE : ex_x);
        n1_y = (ex_y > ONE) ? ONE : ((ex_y < -ONE) ? -ONE : ex_y);
    end

    // A zero component counts as positive when the lower hemisphere is folded.
    always_comb begin
        ax   = r1_x[CW-1] ? -r1_x : r1_x;
        ay   = r1_y[CW-1] ? -r1_y : r1_y;
        n2_z = ONE - ax - ay;
        n2_x = r1_x;
        n2_y = r1_y;
        if (n2_z[CW-1]) begin
            n2_x = r1_x[CW-1] ? -(ONE - ay) : (ONE - ay);
            n2_y = r1_y[CW-1] ? -(ONE - ax) : (ONE - ax);
        end
    end

    assign p_x = r2_x * r2_x;
    assign p_y = r2_y * r2_y;
    assign p_z = r2_z * r2_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x   <= n1_x;
            r1_y   <= n1_y;
            r2_x   <= n2_x;
            r2_y   <= n2_y;
            r2_z   <= n2_z;
            r3_x   <= r2_x;
            r3_y   <= r2_y;
            r3_z   <= r2_z;
            r3_sqx <= p_x[SW-1:0];
            r3_sqy <= p_y[SW-1:0];
            r3_sqz <= p_z[SW-1:0];
            r4_x   <= r3_x;
            r4_y   <= r3_y;
            r4_z   <= r3_z;
            r4_sum <= r3_sqx + r3_sqy + r3_sqz;
        end
    end

    assign o_valid = r_vld[3];
    assign o_x     = r4_x;
    assign o_y     = r4_y;
    assign o_z     = r4_z;
    assign o_sum   = r4_sum;

endmodule

@@ hdl/ond_sqrt.sv @@
// Pipelined square root, one root bit per stage, rounded to nearest at the end.
module ond_sqrt import ond_pkg::*; #(
    parameter int LW = 16,
    parameter int PW = 54
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*LW-1:0] i_s,
    input  logic [PW-1:0]   i_side,
    output logic            o_valid,
    output logic [LW-1:0]   o_len,
    output logic [PW-1:0]   o_side
);

    localparam int SW = 2 * LW;

    logic [SW-1:0] r_rem  [0:LW-1];
    logic [LW-1:0] r_root [0:LW-1];
    logic [PW-1:0] r_side [0:LW-1];
    logic [LW-1:0] r_vld;

    logic [LW-1:0] r_len;
    logic [PW-1:0] r_oside;
    logic          r_ovld;

    for (genvar k = 0; k < LW; k++) begin : g_st
        localparam int B = LW - 1 - k;
        logic [SW-1:0] p_rem, trial;
        logic [LW-1:0] p_root;
        logic [PW-1:0] p_side;
        logic          p_vld;

        if (k == 0) begin : g_first
            assign p_rem  = i_s;
            assign p_root = '0;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
            assign p_vld  = r_vld[k-1];
        end

        // The bits of the partial root all lie above bit B, so the OR acts as an add.
        assign trial = ({{LW{1'b0}}, p_root} << (B + 1))
                     | ({{(SW-1){1'b0}}, 1'b1} << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= p_side;
                if (p_rem >= trial) begin
                    r_rem[k]  <= p_rem - trial;
                    r_root[k] <= p_root | ({{(LW-1){1'b0}}, 1'b1} << B);
                end else begin
                    r_rem[k]  <= p_rem;
                    r_root[k] <= p_root;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_ovld <= r_vld[LW-1];
        end
    end

    // The remainder is s - root^2; above root the true root is nearer root + 1.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oside <= r_side[LW-1];
            r_len   <= r_root[LW-1]
                     + {{(LW-1){1'b0}}, (r_rem[LW-1] > {{LW{1'b0}}, r_root[LW-1]})};
        end
    end

    assign o_valid = r_ovld;
    assign o_len   = r_len;
    assign o_side  = r_oside;

endmodule

@@ hdl/ond_div.sv @@
// Pipelined restoring divider for the three components, one quotient bit per stage.
module ond_div import ond_pkg::*; #(
    parameter int FRAC_BITS = 14,
    parameter int CW        = 18,
    parameter int LW        = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [LW-1:0]        i_len,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_z,
    output logic                 o_valid,
    output logic [OUT_W-1:0]     o_x,
    output logic [OUT_W-1:0]     o_y,
    output logic [OUT_W-1:0]     o_z,
    output logic                 o_flag
);

    localparam int QW = FRAC_BITS + 2;
    localparam int DW = CW + FRAC_BITS + 1;
    localparam int XW = QW + OUT_W;
    localparam logic [QW-1:0] ONE_Q = {{(QW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [XW-1:0] ONE_X = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [DW-1:0] r_rem [0:QW][0:2];
    logic [QW-1:0] r_q   [0:QW][0:2];
    logic [2:0]    r_sg  [0:QW];
    logic [LW-1:0] r_dv  [0:QW];
    logic          r_fl  [0:QW];
    logic [QW:0]   r_vld;

    logic [OUT_W-1:0] r_ox, r_oy, r_oz;
    logic             r_oflag, r_ovld;

    logic signed [CW-1:0] comp [0:2];
    logic [CW-1:0]        mag  [0:2];

    assign comp[0] = i_x;
    assign comp[1] = i_y;
    assign comp[2] = i_z;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            mag[l] = comp[l][CW-1] ? -comp[l] : comp[l];
        end
    end

    // Stage zero forms the rounded numerators |c| * ONE + floor(len / 2).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= ({{(DW-CW){1'b0}}, mag[l]} << FRAC_BITS)
                             + {{(DW-LW+1){1'b0}}, i_len[LW-1:1]};
                r_q[0][l]   <= '0;
                r_sg[0][l]  <= comp[l][CW-1];
            end
            r_dv[0] <= i_len;
            r_fl[0] <= (i_len == '0);
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_st
        localparam int B = QW - k;
        logic [DW-1:0] dshift;

        assign dshift = {{(DW-LW){1'b0}}, r_dv[k-1]} << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    if (r_rem[k-1][l] >= dshift) begin
                        r_rem[k][l] <= r_rem[k-1][l] - dshift;
                        r_q[k][l]   <= r_q[k-1][l] | ({{(QW-1){1'b0}}, 1'b1} << B);
                    end else begin
                        r_rem[k][l] <= r_rem[k-1][l];
                        r_q[k][l]   <= r_q[k-1][l];
                    end
                end
                r_sg[k] <= r_sg[k-1];
                r_dv[k] <= r_dv[k-1];
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_vld  <= {r_vld[QW-1:0], i_valid};
            r_ovld <= r_vld[QW];
        end
    end

    logic [QW-1:0] cq  [0:2];
    logic [XW-1:0] sv  [0:2];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            cq[l] = (r_q[QW][l] > ONE_Q) ? ONE_Q : r_q[QW][l];
            sv[l] = r_sg[QW][l] ? -{{OUT_W{1'b0}}, cq[l]} : {{OUT_W{1'b0}}, cq[l]};
        end
    end

    // A zero length falls back to the straight-up normal.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oflag <= r_fl[QW];
            if (r_fl[QW]) begin
                r_ox <= '0;
                r_oy <= '0;
                r_oz <= ONE_X[OUT_W-1:0];
            end else begin
                r_ox <= sv[0][OUT_W-1:0];
                r_oy <= sv[1][OUT_W-1:0];
                r_oz <= sv[2][OUT_W-1:0];
            end
        end
    end

    assign o_valid = r_ovld;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_z     = r_oz;
    assign o_flag  = r_oflag;

endmodule

@@ hdl/ond_checker.sv @@
// Port-level checks for the octahedral normal decoder, bound to its top level.
module ond_checker import ond_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic [IN_W-1:0]  i_enc_x,
    input logic [IN_W-1:0]  i_enc_y,
    input logic             o_valid,
    input logic             i_ready,
    input logic [OUT_W-1:0] o_norm_x,
    input logic [OUT_W-1:0] o_norm_y,
    input logic [OUT_W-1:0] o_norm_z,
    input logic             o_fell_back
);

    // A stalled result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_norm_x) && $stable(o_norm_y)
                                && $stable(o_norm_z) && $stable(o_fell_back))
        else $error("stalled result changed");

    // Clamped codes never give a zero length.
    a_no_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_fell_back)
        else $error("zero-length fallback on a clamped code");

    // An empty output register never blocks the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

    // At the default format no component reads as 16'h8000, which lies outside plus or minus one.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (FRAC_BITS != 14) || (o_norm_x != 16'h8000 && o_norm_y != 16'h8000
                                          && o_norm_z != 16'h8000))
        else $error("component out of range");

endmodule

bind octahedral_normal_decode_top ond_checker #(.FRAC_BITS(FRAC_BITS)) u_ond_checker (.*);

@@ sim/octahedral_normal_decode_top_test.sv @@
// Testbench for the octahedral normal decoder: random and corner codes checked against a predictor.
`timescale 1ns / 1ps

module octahedral_normal_decode_top_test;
    import ond_pkg::*;

    localparam int FRAC_BITS = 14;
    localparam int LATENCY   = 39;
    localparam longint ONE   = 64'sd1 << FRAC_BITS;

    typedef struct packed {
        logic [IN_W-1:0] enc_x;
        logic [IN_W-1:0] enc_y;
    } code_t;

    typedef struct packed {
        logic [OUT_W-1:0] norm_x;
        logic [OUT_W-1:0] norm_y;
        logic [OUT_W-1:0] norm_z;
        logic             fell_back;
    } normal_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [IN_W-1:0]  i_enc_x;
    logic [IN_W-1:0]  i_enc_y;
    logic             o_valid;
    logic             i_ready;
    logic [OUT_W-1:0] o_norm_x;
    logic [OUT_W-1:0] o_norm_y;
    logic [OUT_W-1:0] o_norm_z;
    logic             o_fell_back;

    code_t   pending_codes[$];
    normal_t expected_normals[$];
    int      error_count = 0;
    bit      drain_hold;
    int      hold_requests = 0;
    int      holds_done;
    int      hold_cycles;
    int      burst_left;
    int      gap_left;
    int      stall_left;
    int      run_left;

    octahedral_normal_decode_top #(.FRAC_BITS(FRAC_BITS)) dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint clamp_unit(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function automatic longint abs_val(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Bitwise integer square root, floor.
    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [OUT_W-1:0] unit_scale(longint c, longint unsigned len);
        longint unsigned q;
        longint r;
        q = ((longint'(abs_val(c)) << FRAC_BITS) + (len >> 1)) / len;
        r = longint'(q);
        r = clamp_unit(c < 0 ? -r : r);
        return r[OUT_W-1:0];
    endfunction

    function automatic normal_t decode_normal(code_t c);
        longint x, y, z, fx, fy;
        longint unsigned s, len;
        normal_t n;
        x = clamp_unit(longint'($signed(c.enc_x)));
        y = clamp_unit(longint'($signed(c.enc_y)));
        z = ONE - abs_val(x) - abs_val(y);
        if (z < 0) begin
            // Lower hemisphere: fold, with zero counting as positive.
            fx = (ONE - abs_val(y)) * ((x >= 0) ? 1 : -1);
            fy = (ONE - abs_val(x)) * ((y >= 0) ? 1 : -1);
            x = fx;
            y = fy;
        end
        s = x * x + y * y + z * z;
        len = root_floor(s);
        if (s - len * len > len) len += 1;
        if (len == 0) begin
            n.norm_x = '0;
            n.norm_y = '0;
            n.norm_z = ONE[OUT_W-1:0];
            n.fell_back = 1'b1;
        end else begin
            n.norm_x = unit_scale(x, len);
            n.norm_y = unit_scale(y, len);
            n.norm_z = unit_scale(z, len);
            n.fell_back = 1'b0;
        end
        return n;
    endfunction

    function automatic logic [IN_W-1:0] rand_comp();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return IN_W'($urandom);
        if (k == 1) return IN_W'(($urandom_range(0, 1) != 0) ? ONE : -ONE);
        if (k == 2) return IN_W'($urandom_range(0, 3) - 2);
        return IN_W'(int'($urandom_range(0, 2 * ONE)) - int'(ONE));
    endfunction

    task automatic add_code(longint x, longint y);
        code_t c;
        c.enc_x = IN_W'(x);
        c.enc_y = IN_W'(y);
        pending_codes.push_back(c);
    endtask

    // Driver: bursts of random length with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_enc_x <= '0;
            i_enc_y <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) pending_codes.pop_front();
            if (gap_left > 0 || drain_hold || pending_codes.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                i_valid <= 1'b1;
                i_enc_x <= pending_codes[0].enc_x;
                i_enc_y <= pending_codes[0].enc_y;
                expected_normals.push_back(decode_normal(pending_codes[0]));
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver stall pattern plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
            run_left <= 0;
            hold_cycles <= 0;
            holds_done <= 0;
        end else if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (holds_done != hold_requests) begin
            i_ready <= 1'b0;
            hold_cycles <= 149;
            holds_done <= holds_done + 1;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (run_left > 0) begin
            i_ready <= 1'b1;
            run_left <= run_left - 1;
        end else begin
            i_ready <= 1'b1;
            run_left <= $urandom_range(0, 30);
            stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
    end

    // Monitor: compare each accepted result with the oldest expected normal.
    always @(posedge i_clk) begin
        normal_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_normals.size() == 0) begin
                $error("unexpected result x=%h y=%h z=%h", o_norm_x, o_norm_y, o_norm_z);
                error_count++;
            end else begin
                want = expected_normals.pop_front();
                if (o_norm_x !== want.norm_x) begin
                    $error("norm_x expected %h got %h", want.norm_x, o_norm_x);
                    error_count++;
                end
                if (o_norm_y !== want.norm_y) begin
                    $error("norm_y expected %h got %h", want.norm_y, o_norm_y);
                    error_count++;
                end
                if (o_norm_z !== want.norm_z) begin
                    $error("norm_z expected %h got %h", want.norm_z, o_norm_z);
                    error_count++;
                end
                if (o_fell_back !== want.fell_back) begin
                    $error("fell_back expected %b got %b", want.fell_back, o_fell_back);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int half;
        drain_hold = 1'b0;
        i_rst_n = 1'b0;
        // Corners, axes, out-of-range codes and codes with zero components.
        add_code(0, 0);
        add_code(ONE, 0);
        add_code(-ONE, 0);
        add_code(0, ONE);
        add_code(0, -ONE);
        add_code(ONE, ONE);
        add_code(-ONE, -ONE);
        add_code(ONE, -ONE);
        add_code(-ONE, ONE);
        add_code(32767, -32768);
        add_code(-32768, 32767);
        add_code(16385, 0);
        add_code(-16385, 5);
        add_code(ONE / 2, ONE / 2);
        add_code(ONE / 2 + 1, ONE / 2);
        add_code(-ONE / 2, ONE / 2 + 7);
        add_code(0, 12000);
        add_code(12000, 0);
        add_code(1, -1);
        add_code(-1, 1);
        add_code(16'h5555, 16'haaaa);
        add_code(16'haaaa, 16'h5555);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 200; i++) add_code(rand_comp(), rand_comp());
        wait (pending_codes.size() == 0);
        // Pause the sender until every expected result has drained.
        drain_hold = 1'b1;
        wait (expected_normals.size() == 0);
        @(posedge i_clk);
        // Long hold-off while the sender keeps offering requests.
        hold_requests++;
        drain_hold = 1'b0;
        half = 250;
        for (int i = 0; i < half; i++) add_code(rand_comp(), rand_comp());
        for (int i = 0; i < 250; i++) add_code(rand_comp(), rand_comp());
        wait (pending_codes.size() == 0);
        wait (expected_normals.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
